[sv/gmfp_pkg.sv]
`timescale 1ns / 1ps

package gmfp_pkg;

	// Field widths
	localparam int VAL_W  = 16;
	localparam int SUM_W  = 22;
	localparam int COL_W  = 7;
	localparam int GRID_W = 7;

	// Saturation ceiling of a path sum
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Side of the grid after reset
	localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic shift;     // advance on an accepted beat
		logic take_new;  // this cell is the tail and takes the fresh sum
	} cell_ctrl_t;

endpackage

[sv/gmfp_ifs.sv]
`timescale 1ns / 1ps

// Grid cell stream
interface gmfp_cell_if;
	logic                          valid;
	logic                          ready;
	logic [gmfp_pkg::VAL_W-1:0]    cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink   (input valid, input cell_value, output ready);
endinterface

// Result stream
interface gmfp_result_if;
	logic                          valid;
	logic                          ready;
	logic [gmfp_pkg::SUM_W-1:0]    best_sum;
	logic [gmfp_pkg::COL_W-1:0]    best_column;

	modport source (output valid, output best_sum, output best_column, input ready);
	modport sink   (input valid, input best_sum, input best_column, output ready);
endinterface

// Grid size write channel
interface gmfp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [gmfp_pkg::GRID_W-1:0]   grid_size;

	modport source (output valid, output grid_size, input ready);
	modport sink   (input valid, input grid_size, output ready);
endinterface

[sv/gmfp_cell.sv]
`timescale 1ns / 1ps

// One link of the row-sum chain: holds one previous-row path sum and
// passes it towards the head on every accepted beat.
module gmfp_cell (
	input  logic                         clk,
	input  gmfp_pkg::cell_ctrl_t         ctrl,
	input  logic [gmfp_pkg::SUM_W-1:0]   from_next,
	input  logic [gmfp_pkg::SUM_W-1:0]   new_sum,
	output logic [gmfp_pkg::SUM_W-1:0]   sum_q
);

	// Take the neighbour's sum, or the fresh one at the tail
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			sum_q <= ctrl.take_new ? new_sum : from_next;
		end
	end

endmodule

[sv/gmfp_step.sv]
`timescale 1ns / 1ps

// Path sum of one cell: value plus the largest of the present neighbours
// above, saturated to the sum width.
module gmfp_step (
	input  logic [gmfp_pkg::VAL_W-1:0]   cell_value,
	input  logic                         first_row,
	input  logic                         use_left,
	input  logic                         use_right,
	input  logic [gmfp_pkg::SUM_W-1:0]   above_left,
	input  logic [gmfp_pkg::SUM_W-1:0]   above,
	input  logic [gmfp_pkg::SUM_W-1:0]   above_right,
	output logic [gmfp_pkg::SUM_W-1:0]   sum
);

	logic [gmfp_pkg::SUM_W-1:0] left_v;
	logic [gmfp_pkg::SUM_W-1:0] right_v;
	logic [gmfp_pkg::SUM_W-1:0] best_lu;
	logic [gmfp_pkg::SUM_W-1:0] best;
	logic [gmfp_pkg::SUM_W:0]   raw;

	// Drop absent neighbours, pick the largest
	always_comb begin
		left_v  = use_left ? above_left : '0;
		right_v = use_right ? above_right : '0;
		best_lu = (left_v > above) ? left_v : above;
		best    = (right_v > best_lu) ? right_v : best_lu;
		if (first_row) begin
			best = '0;
		end
	end

	// Add and saturate
	assign raw = {1'b0, best} + (gmfp_pkg::SUM_W + 1)'(cell_value);
	assign sum = raw[gmfp_pkg::SUM_W] ? gmfp_pkg::SUM_MAX : raw[gmfp_pkg::SUM_W-1:0];

endmodule

[sv/grid_max_falling_path_unit.sv]
`timescale 1ns / 1ps

// Channel | Dir | Payload                  | Beat when
// cells   | in  | cell_value               | cells.valid && cells.ready
// result  | out | best_sum, best_column    | result.valid && result.ready
// cfg     | in  | grid_size                | cfg.valid && cfg.ready
//
// One grid cell is taken every cycle; the add-compare of a cell is
// combinational and its sum enters the previous-row chain as the cell is
// taken, the bottom-row best is kept one stage later. The last cell passes
// stage 1 and then loads the result register. Reset restores a side of 64;
// no clearing pass is needed. Input stalls only while a finished result is
// held and another last cell waits behind it.
module grid_max_falling_path_unit #(
	parameter int MAX_SIDE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	gmfp_cell_if.sink             cells,
	gmfp_result_if.source         result,
	gmfp_cfg_if.sink              cfg
);

	localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	logic [gmfp_pkg::GRID_W-1:0]  grid_size_q;
	logic [31:0]                  side32;
	logic [IW-1:0]                side_m1;

	logic [IW-1:0]                row_q;
	logic [IW-1:0]                col_q;
	logic [gmfp_pkg::SUM_W-1:0]   left_hold_q;

	logic [gmfp_pkg::SUM_W-1:0]   chain_w [MAX_SIDE+1];
	gmfp_pkg::cell_ctrl_t         ctrl_w  [MAX_SIDE];

	logic                         accept;
	logic                         s2_block;
	logic                         col_last;
	logic                         row_last;
	logic [gmfp_pkg::SUM_W-1:0]   new_sum;

	logic                         valid_s1;
	logic [gmfp_pkg::SUM_W-1:0]   sum_s1;
	logic [IW-1:0]                col_s1;
	logic                         bottom_s1;
	logic                         last_s1;

	logic [gmfp_pkg::SUM_W-1:0]   run_best_q;
	logic [IW-1:0]                run_col_q;
	logic [gmfp_pkg::SUM_W-1:0]   next_best;
	logic [IW-1:0]                next_col;

	logic                         out_valid_q;
	logic [gmfp_pkg::SUM_W-1:0]   out_sum_q;
	logic [gmfp_pkg::COL_W-1:0]   out_col_q;

	// Clamp the side in use to 1..MAX_SIDE
	always_comb begin
		side32 = 32'(grid_size_q);
		if (side32 == 32'd0) begin
			side32 = 32'd1;
		end else if (side32 > 32'(MAX_SIDE)) begin
			side32 = 32'(MAX_SIDE);
		end
		side_m1 = IW'(side32 - 32'd1);
	end

	// Handshakes
	assign s2_block    = valid_s1 && last_s1 && out_valid_q && !result.ready;
	assign cells.ready = !s2_block;
	assign cfg.ready   = 1'b1;
	assign accept      = cells.valid && cells.ready;

	assign col_last = (col_q == side_m1);
	assign row_last = (row_q == side_m1);

	// Row of cells; the tail is the cell at the side in use
	assign chain_w[MAX_SIDE] = new_sum;

	for (genvar i = 0; i < MAX_SIDE; i++) begin : g_chain
		always_comb begin
			ctrl_w[i].shift    = accept;
			ctrl_w[i].take_new = (IW'(i) == side_m1);
		end

		gmfp_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl_w[i]),
			.from_next (chain_w[i+1]),
			.new_sum   (new_sum),
			.sum_q     (chain_w[i])
		);
	end

	// Path sum of the arriving cell
	gmfp_step u_step (
		.cell_value  (cells.cell_value),
		.first_row   (row_q == '0),
		.use_left    (col_q != '0),
		.use_right   (!col_last),
		.above_left  (left_hold_q),
		.above       (chain_w[0]),
		.above_right (chain_w[1]),
		.sum         (new_sum)
	);

	// Advance row and column, keep the sum above for the next column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= gmfp_pkg::GRID_RESET;
			row_q       <= '0;
			col_q       <= '0;
			left_hold_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			grid_size_q <= cfg.grid_size;
			row_q       <= '0;
			col_q       <= '0;
			left_hold_q <= '0;
		end else if (accept) begin
			left_hold_q <= chain_w[0];
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + IW'(1);
			end else begin
				col_q <= col_q + IW'(1);
			end
		end
	end

	// Stage 1: hold the sum and its position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!s2_block) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1    <= new_sum;
			col_s1    <= col_q;
			bottom_s1 <= row_last;
			last_s1   <= row_last && col_last;
		end
	end

	// Bottom-row best, leftmost on ties
	always_comb begin
		next_best = run_best_q;
		next_col  = run_col_q;
		if (bottom_s1 && (col_s1 == '0 || sum_s1 > run_best_q)) begin
			next_best = sum_s1;
			next_col  = col_s1;
		end
	end

	// Stage 2: track the best and load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_best_q  <= '0;
			run_col_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			run_best_q <= '0;
			run_col_q  <= '0;
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s1 && !s2_block) begin
				if (last_s1) begin
					run_best_q  <= '0;
					run_col_q   <= '0;
					out_valid_q <= 1'b1;
				end else begin
					run_best_q <= next_best;
					run_col_q  <= next_col;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && !s2_block) begin
			out_sum_q <= next_best;
			out_col_q <= gmfp_pkg::COL_W'(32'(next_col) + 32'd1);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.best_sum    = out_sum_q;
	assign result.best_column = out_col_q;

endmodule
